/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the cycle distance block.
// Clocked on clock, disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// ante implies cons in the same cycle
`define ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
// ante implies cons in the next cycle
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

/* hw/rtl/cdu_pkg.sv */
// Shared types and constants for the cycle distance block.
// No dependencies.
package cdu_pkg;
   localparam int DEFAULT_MAX_NODES = 4096;
   localparam int FIELD_W = 13;
   localparam int HOP_W = 12;
   localparam int DIST_W = HOP_W + 2;
   localparam logic [HOP_W-1:0] HOP_MAX = '1;
   localparam logic [FIELD_W-1:0] RESET_NODE_COUNT = 13'd4096;
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic load;
      logic start;
      logic [FIELD_W-1:0] end_a;
      logic [FIELD_W-1:0] end_b;
      logic [FIELD_W-1:0] query_node;
   } cdu_cmd_type;

   typedef struct packed {
      logic busy;
      logic full;
      logic visited;
      logic on_cycle;
      logic [HOP_W-1:0] hop;
   } cdu_stat_type;
endpackage

/* hw/rtl/cdu_engine.sv */
// Edge store, adjacency build, bridge search and BFS sequencer over on-chip memories.
// Depends on cdu_pkg and assert_macros.svh.
`include "assert_macros.svh"
module cdu_engine import cdu_pkg::*; #(
   parameter int MAX_NODES = DEFAULT_MAX_NODES,
   localparam int VW = $clog2(MAX_NODES + 2)
) (
   input  logic clock,
   input  logic reset,
   input  logic [VW-1:0] n_nodes,
   input  cdu_cmd_type cmd,
   output cdu_stat_type stat
);
   localparam int ND = MAX_NODES + 2;
   localparam int OW = $clog2(2 * MAX_NODES + 1);
   localparam int AW = $clog2(2 * MAX_NODES);
   localparam int EW = $clog2(MAX_NODES);

   localparam logic [4:0] S_IDLE = 5'd0, S_CLR = 5'd1, S_DEG_RD = 5'd2, S_DEG_A = 5'd3,
      S_DEG_AW = 5'd4, S_DEG_BW = 5'd5, S_SUM_RD = 5'd6, S_SUM_WR = 5'd7,
      S_FIL_RD = 5'd8, S_FIL_A = 5'd9, S_FIL_AW = 5'd10, S_FIL_BW = 5'd11,
      S_RT_RD = 5'd12, S_RT_CK = 5'd13, S_DF_IT = 5'd14, S_DF_CK = 5'd15,
      S_DF_NB = 5'd16, S_DF_W = 5'd17, S_RET = 5'd18, S_RET2 = 5'd19, S_RET3 = 5'd20,
      S_SD_RD = 5'd21, S_SD_CK = 5'd22, S_BF_HD = 5'd23, S_BF_C = 5'd24,
      S_BF_IT0 = 5'd25, S_BF_IT = 5'd26, S_BF_W = 5'd27, S_BF_WC = 5'd28;

   logic [2*FIELD_W-1:0] edge_mem [MAX_NODES];
   logic [OW-1:0] begin_mem [ND];
   logic [OW-1:0] fill_mem [ND];
   logic [VW-1:0] adj_mem [2*MAX_NODES];
   logic [VW-1:0] disc_mem [ND];
   logic [VW-1:0] low_mem [ND];
   logic [VW-1:0] par_mem [ND];
   logic cyc_mem [ND];
   logic [DIST_W-1:0] dist_mem [ND];
   logic [VW-1:0] queue_mem [MAX_NODES];

   logic edge_we, begin_we, fill_we, adj_we, disc_we, low_we, par_we, cyc_we, dist_we, q_we;
   logic [EW-1:0] edge_wa, edge_ra, q_wa, q_ra;
   logic [2*FIELD_W-1:0] edge_wd, edge_rd;
   logic [VW-1:0] begin_wa, begin_ra, fill_wa, fill_ra, disc_wa, disc_ra, low_wa, low_ra;
   logic [VW-1:0] par_wa, par_ra, cyc_wa, cyc_ra, dist_wa, dist_ra;
   logic [OW-1:0] begin_wd, begin_rd, fill_wd, fill_rd;
   logic [AW-1:0] adj_wa, adj_ra;
   logic [VW-1:0] adj_wd, adj_rd, disc_wd, disc_rd, low_wd, low_rd, par_wd, par_rd;
   logic [VW-1:0] q_wd, q_rd;
   logic cyc_wd, cyc_rd;
   logic [DIST_W-1:0] dist_wd, dist_rd;

   logic [4:0] state_ff, state_in;
   logic [VW-1:0] cnt_ff, cnt_in, v_ff, v_in, e_ff, e_in, ea_ff, ea_in, eb_ff, eb_in;
   logic [VW-1:0] cur_ff, cur_in, up_ff, up_in, low_ff, low_in, t_ff, t_in, w_ff, w_in;
   logic [VW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [OW-1:0] acc_ff, acc_in, k_ff, k_in, kend_ff, kend_in;
   logic [HOP_W-1:0] d_ff, d_in;

   logic [FIELD_W-1:0] rd_a, rd_b;
   logic edge_ok, full;
   logic [VW-1:0] np1;
   logic [OW-1:0] sum, fill_m1;

   function automatic logic node_ok(input logic [FIELD_W-1:0] x, input logic [VW-1:0] n);
      return (x != '0) && (32'(x) <= 32'(n));
   endfunction

   assign rd_a = edge_rd[2*FIELD_W-1:FIELD_W];
   assign rd_b = edge_rd[FIELD_W-1:0];
   assign edge_ok = node_ok(rd_a, n_nodes) && node_ok(rd_b, n_nodes) && (rd_a != rd_b);
   assign full = cnt_ff >= n_nodes;
   assign np1 = n_nodes + VW'(1);
   assign sum = acc_ff + begin_rd;
   assign fill_m1 = fill_rd - OW'(1);

   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; v_in = v_ff; e_in = e_ff;
      ea_in = ea_ff; eb_in = eb_ff; cur_in = cur_ff; up_in = up_ff; low_in = low_ff;
      t_in = t_ff; w_in = w_ff; head_in = head_ff; tail_in = tail_ff;
      acc_in = acc_ff; k_in = k_ff; kend_in = kend_ff; d_in = d_ff;
      edge_we = cmd.load && !full && (state_ff == S_IDLE);
      edge_wa = cnt_ff[EW-1:0];
      edge_wd = {cmd.end_a, cmd.end_b};
      edge_ra = e_ff[EW-1:0];
      begin_we = 1'b0; begin_wa = '0; begin_wd = '0; begin_ra = '0;
      fill_we = 1'b0; fill_wa = '0; fill_wd = '0; fill_ra = '0;
      adj_we = 1'b0; adj_wa = '0; adj_wd = '0; adj_ra = '0;
      disc_we = 1'b0; disc_wa = '0; disc_wd = '0; disc_ra = '0;
      low_we = 1'b0; low_wa = '0; low_wd = '0; low_ra = '0;
      par_we = 1'b0; par_wa = '0; par_wd = '0; par_ra = '0;
      cyc_we = 1'b0; cyc_wa = '0; cyc_wd = 1'b0; cyc_ra = '0;
      dist_we = 1'b0; dist_wa = '0; dist_wd = '0; dist_ra = VW'(cmd.query_node);
      q_we = 1'b0; q_wa = tail_ff[EW-1:0]; q_wd = '0; q_ra = head_ff[EW-1:0];
      if (edge_we) begin
         cnt_in = cnt_ff + VW'(1);
      end
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.start) begin
               v_in = '0; head_in = '0; tail_in = '0;
               state_in = S_CLR;
            end
         end
         S_CLR: begin
            begin_we = 1'b1; begin_wa = v_ff;
            disc_we = 1'b1; disc_wa = v_ff;
            cyc_we = 1'b1; cyc_wa = v_ff;
            dist_we = 1'b1; dist_wa = v_ff;
            if (v_ff == np1) begin
               e_in = '0; state_in = S_DEG_RD;
            end else begin
               v_in = v_ff + VW'(1);
            end
         end
         S_DEG_RD: begin
            if (e_ff == cnt_ff) begin
               acc_in = '0; v_in = VW'(1); state_in = S_SUM_RD;
            end else begin
               state_in = S_DEG_A;
            end
         end
         S_DEG_A: begin
            ea_in = VW'(rd_a); eb_in = VW'(rd_b);
            begin_ra = VW'(rd_a) + VW'(1);
            if (edge_ok) begin
               state_in = S_DEG_AW;
            end else begin
               e_in = e_ff + VW'(1); state_in = S_DEG_RD;
            end
         end
         S_DEG_AW: begin
            begin_we = 1'b1; begin_wa = ea_ff + VW'(1); begin_wd = begin_rd + OW'(1);
            begin_ra = eb_ff + VW'(1);
            state_in = S_DEG_BW;
         end
         S_DEG_BW: begin
            begin_we = 1'b1; begin_wa = eb_ff + VW'(1); begin_wd = begin_rd + OW'(1);
            e_in = e_ff + VW'(1); state_in = S_DEG_RD;
         end
         S_SUM_RD: begin
            begin_ra = v_ff; state_in = S_SUM_WR;
         end
         S_SUM_WR: begin
            begin_we = 1'b1; begin_wa = v_ff; begin_wd = sum;
            fill_we = 1'b1; fill_wa = v_ff; fill_wd = sum;
            acc_in = sum;
            if (v_ff == np1) begin
               e_in = '0; state_in = S_FIL_RD;
            end else begin
               v_in = v_ff + VW'(1); state_in = S_SUM_RD;
            end
         end
         S_FIL_RD: begin
            if (e_ff == cnt_ff) begin
               v_in = VW'(1); t_in = '0; state_in = S_RT_RD;
            end else begin
               state_in = S_FIL_A;
            end
         end
         S_FIL_A: begin
            ea_in = VW'(rd_a); eb_in = VW'(rd_b);
            fill_ra = VW'(rd_a);
            if (edge_ok) begin
               state_in = S_FIL_AW;
            end else begin
               e_in = e_ff + VW'(1); state_in = S_FIL_RD;
            end
         end
         S_FIL_AW: begin
            adj_we = 1'b1; adj_wa = fill_rd[AW-1:0]; adj_wd = eb_ff;
            fill_we = 1'b1; fill_wa = ea_ff; fill_wd = fill_rd + OW'(1);
            fill_ra = eb_ff;
            state_in = S_FIL_BW;
         end
         S_FIL_BW: begin
            adj_we = 1'b1; adj_wa = fill_rd[AW-1:0]; adj_wd = ea_ff;
            fill_we = 1'b1; fill_wa = eb_ff; fill_wd = fill_rd + OW'(1);
            e_in = e_ff + VW'(1); state_in = S_FIL_RD;
         end
         S_RT_RD: begin
            if (v_ff == np1) begin
               v_in = VW'(1); tail_in = '0; state_in = S_SD_RD;
            end else begin
               disc_ra = v_ff; state_in = S_RT_CK;
            end
         end
         S_RT_CK: begin
            if (disc_rd != '0) begin
               v_in = v_ff + VW'(1); state_in = S_RT_RD;
            end else begin
               disc_we = 1'b1; disc_wa = v_ff; disc_wd = t_ff + VW'(1);
               par_we = 1'b1; par_wa = v_ff;
               cur_in = v_ff; up_in = '0; low_in = t_ff + VW'(1); t_in = t_ff + VW'(1);
               state_in = S_DF_IT;
            end
         end
         S_DF_IT: begin
            fill_ra = cur_ff; begin_ra = cur_ff; state_in = S_DF_CK;
         end
         S_DF_CK: begin
            if (fill_rd > begin_rd) begin
               fill_we = 1'b1; fill_wa = cur_ff; fill_wd = fill_m1;
               adj_ra = fill_m1[AW-1:0];
               state_in = S_DF_NB;
            end else begin
               state_in = S_RET;
            end
         end
         S_DF_NB: begin
            w_in = adj_rd; disc_ra = adj_rd;
            state_in = (adj_rd == up_ff) ? S_DF_IT : S_DF_W;
         end
         S_DF_W: begin
            if (disc_rd == '0) begin
               disc_we = 1'b1; disc_wa = w_ff; disc_wd = t_ff + VW'(1);
               par_we = 1'b1; par_wa = w_ff; par_wd = cur_ff;
               low_we = 1'b1; low_wa = cur_ff; low_wd = low_ff;
               up_in = cur_ff; cur_in = w_ff; low_in = t_ff + VW'(1); t_in = t_ff + VW'(1);
            end else if (disc_rd < low_ff) begin
               low_in = disc_rd;
            end
            state_in = S_DF_IT;
         end
         S_RET: begin
            disc_ra = up_ff; low_ra = up_ff; par_ra = up_ff;
            if (up_ff == '0) begin
               v_in = v_ff + VW'(1); state_in = S_RT_RD;
            end else begin
               state_in = S_RET2;
            end
         end
         S_RET2: begin
            cur_in = up_ff; up_in = par_rd;
            low_in = (low_rd < low_ff) ? low_rd : low_ff;
            if (low_ff <= disc_rd) begin
               cyc_we = 1'b1; cyc_wa = cur_ff; cyc_wd = 1'b1;
               state_in = S_RET3;
            end else begin
               state_in = S_DF_IT;
            end
         end
         S_RET3: begin
            cyc_we = 1'b1; cyc_wa = cur_ff; cyc_wd = 1'b1;
            state_in = S_DF_IT;
         end
         S_SD_RD: begin
            if (v_ff == np1) begin
               head_in = '0; state_in = S_BF_HD;
            end else begin
               cyc_ra = v_ff; state_in = S_SD_CK;
            end
         end
         S_SD_CK: begin
            if (cyc_rd) begin
               dist_we = 1'b1; dist_wa = v_ff; dist_wd = {2'b11, HOP_W'(0)};
               q_we = 1'b1; q_wd = v_ff; tail_in = tail_ff + VW'(1);
            end
            v_in = v_ff + VW'(1); state_in = S_SD_RD;
         end
         S_BF_HD: begin
            if (head_ff == tail_ff) begin
               state_in = S_IDLE;
            end else begin
               head_in = head_ff + VW'(1); state_in = S_BF_C;
            end
         end
         S_BF_C: begin
            dist_ra = q_rd; fill_ra = q_rd; begin_ra = q_rd + VW'(1);
            state_in = S_BF_IT0;
         end
         S_BF_IT0: begin
            d_in = dist_rd[HOP_W-1:0]; k_in = fill_rd; kend_in = begin_rd;
            state_in = S_BF_IT;
         end
         S_BF_IT: begin
            adj_ra = k_ff[AW-1:0];
            if (k_ff < kend_ff) begin
               k_in = k_ff + OW'(1); state_in = S_BF_W;
            end else begin
               state_in = S_BF_HD;
            end
         end
         S_BF_W: begin
            w_in = adj_rd; dist_ra = adj_rd; state_in = S_BF_WC;
         end
         S_BF_WC: begin
            if (!dist_rd[DIST_W-1]) begin
               dist_we = 1'b1; dist_wa = w_ff;
               dist_wd = {2'b10, (d_ff == HOP_MAX) ? d_ff : d_ff + HOP_W'(1)};
               q_we = 1'b1; q_wd = w_ff; tail_in = tail_ff + VW'(1);
            end
            state_in = S_BF_IT;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (edge_we) edge_mem[edge_wa] <= edge_wd;
      edge_rd <= edge_mem[edge_ra];
      if (begin_we) begin_mem[begin_wa] <= begin_wd;
      begin_rd <= begin_mem[begin_ra];
      if (fill_we) fill_mem[fill_wa] <= fill_wd;
      fill_rd <= fill_mem[fill_ra];
      if (adj_we) adj_mem[adj_wa] <= adj_wd;
      adj_rd <= adj_mem[adj_ra];
      if (disc_we) disc_mem[disc_wa] <= disc_wd;
      disc_rd <= disc_mem[disc_ra];
      if (low_we) low_mem[low_wa] <= low_wd;
      low_rd <= low_mem[low_ra];
      if (par_we) par_mem[par_wa] <= par_wd;
      par_rd <= par_mem[par_ra];
      if (cyc_we) cyc_mem[cyc_wa] <= cyc_wd;
      cyc_rd <= cyc_mem[cyc_ra];
      if (dist_we) dist_mem[dist_wa] <= dist_wd;
      dist_rd <= dist_mem[dist_ra];
      if (q_we) queue_mem[q_wa] <= q_wd;
      q_rd <= queue_mem[q_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         head_ff <= '0;
         tail_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
      v_ff <= v_in; e_ff <= e_in; ea_ff <= ea_in; eb_ff <= eb_in;
      cur_ff <= cur_in; up_ff <= up_in; low_ff <= low_in; t_ff <= t_in; w_ff <= w_in;
      acc_ff <= acc_in; k_ff <= k_in; kend_ff <= kend_in; d_ff <= d_in;
   end

   assign stat.busy = state_ff != S_IDLE;
   assign stat.full = full;
   assign stat.visited = dist_rd[DIST_W-1];
   assign stat.on_cycle = dist_rd[DIST_W-2];
   assign stat.hop = dist_rd[HOP_W-1:0];

   `ASSERT_IMPL(a_queue_bound, state_ff != S_IDLE, (head_ff <= tail_ff) && (tail_ff <= n_nodes))
   `ASSERT_IMPL(a_dfs_node, state_ff == S_DF_IT, (t_ff <= n_nodes) && (cur_ff != '0))
endmodule

/* hw/rtl/cycle_distance_in_unicyclic_graph.sv */
// Distance to the cycle: edges are loaded one per transfer, and queries are answered from
// the stored distances when the response register is free. The first query after a stored
// edge load or a node_count write runs a compute pass first, stepping a sequencer through
// clear, degree count, prefix sum, adjacency fill, bridge search and BFS. Depends on
// cdu_pkg, cdu_engine, assert_macros.svh.
`include "assert_macros.svh"
module cycle_distance_in_unicyclic_graph import cdu_pkg::*; #(
   parameter int MAX_NODES = DEFAULT_MAX_NODES
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_operation,
   input  logic [FIELD_W-1:0] req_end_a,
   input  logic [FIELD_W-1:0] req_end_b,
   input  logic [FIELD_W-1:0] req_query_node,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [HOP_W-1:0] rsp_hop_count,
   output logic rsp_lies_on_cycle,
   output logic rsp_unreachable,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [FIELD_W-1:0] csr_node_count
);
   localparam int VW = $clog2(MAX_NODES + 2);
   localparam logic [1:0] T_IDLE = 2'd0, T_PASS = 2'd1, T_WAIT = 2'd2;

   logic [1:0] state_ff, state_in;
   logic ready_ff, ready_in, rsp_valid_ff, rsp_valid_in, q_ok_ff, q_ok_in;
   logic [FIELD_W-1:0] q_ff, q_in, node_count_ff, node_count_in;
   logic [HOP_W-1:0] hop_ff, hop_in;
   logic cyc_ff, cyc_in, unr_ff, unr_in;
   logic [VW-1:0] n_nodes;
   logic req_fire, ok;
   cdu_cmd_type eng_cmd;
   cdu_stat_type eng_stat;

   assign n_nodes = (32'(node_count_ff) > 32'(MAX_NODES)) ? VW'(MAX_NODES)
                                                          : VW'(node_count_ff);
   assign req_ready = state_ff == T_IDLE;
   assign req_fire = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign ok = q_ok_ff && eng_stat.visited;

   assign eng_cmd.load = req_fire && (req_operation == OP_LOAD);
   assign eng_cmd.start = req_fire && (req_operation == OP_QUERY) && !ready_ff;
   assign eng_cmd.end_a = req_end_a;
   assign eng_cmd.end_b = req_end_b;
   assign eng_cmd.query_node = (state_ff == T_IDLE) ? req_query_node : q_ff;

   always_comb begin
      state_in = state_ff; ready_in = ready_ff; rsp_valid_in = rsp_valid_ff;
      q_in = q_ff; q_ok_in = q_ok_ff; node_count_in = node_count_ff;
      hop_in = hop_ff; cyc_in = cyc_ff; unr_in = unr_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (csr_valid && csr_ready) begin
         node_count_in = csr_node_count; ready_in = 1'b0;
      end
      unique case (state_ff)
         T_IDLE: begin
            if (req_fire) begin
               if (req_operation == OP_LOAD) begin
                  if (!eng_stat.full) ready_in = 1'b0;
               end else begin
                  q_in = req_query_node;
                  q_ok_in = (req_query_node != '0) && (32'(req_query_node) <= 32'(n_nodes));
                  state_in = ready_ff ? T_WAIT : T_PASS;
               end
            end
         end
         T_PASS: begin
            if (!eng_stat.busy) begin
               ready_in = 1'b1; state_in = T_WAIT;
            end
         end
         T_WAIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               hop_in = ok ? eng_stat.hop : '0;
               cyc_in = ok && eng_stat.on_cycle;
               unr_in = !ok;
               state_in = T_IDLE;
            end
         end
         default: state_in = T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
         ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         node_count_ff <= RESET_NODE_COUNT;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
         node_count_ff <= node_count_in;
      end
      q_ff <= q_in; q_ok_ff <= q_ok_in;
      hop_ff <= hop_in; cyc_ff <= cyc_in; unr_ff <= unr_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hop_count = hop_ff;
   assign rsp_lies_on_cycle = cyc_ff;
   assign rsp_unreachable = unr_ff;

   cdu_engine #(.MAX_NODES(MAX_NODES)) u_engine (
      .clock(clock),
      .reset(reset),
      .n_nodes(n_nodes),
      .cmd(eng_cmd),
      .stat(eng_stat)
   );

   `ASSERT_IMPL(a_no_accept_busy, eng_stat.busy, !req_ready)
   `ASSERT_NEXT(a_pass_starts, eng_cmd.start, eng_stat.busy)
   `ASSERT_IMPL(a_wait_idle, state_ff == T_WAIT, !eng_stat.busy)
endmodule
